// ===== hw/rtl/ket_pkg.sv =====
// Shared types, widths and helpers of the key event tracker.
// No dependencies; every other file of the block refers to it by scoped names.
package ket_pkg;

  localparam int NUM_KEYS   = 256;
  localparam int FIFO_DEPTH = 256;
  localparam int CMDQ_DEPTH = 2;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 8;
  localparam int CODE_W   = 23;
  localparam int TIME_W   = 63;
  localparam int DROP_W   = 32;
  localparam int OFFSET_W = 64;

  localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int FIFO_AW   = $clog2(FIFO_DEPTH);
  localparam int CMDQ_AW   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW   = $clog2(CMDQ_DEPTH + 1);

  localparam logic [KEY_W-1:0] NULL_KEY    = 8'd0;
  localparam logic [KEY_W-1:0] IGNORED_KEY = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_KEY        = 2'd0,
    OP_FOCUS_LOST = 2'd1,
    OP_POP        = 2'd2,
    OP_DROP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_ENQ       = 2'd0,
    CMD_POP       = 2'd1,
    CMD_DROP_READ = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
    logic              press;
    logic [TIME_W-1:0] stamp;
  } item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
    logic              press;
    logic [TIME_W-1:0] stamp;
  } cmd_t;

  // request from the front end into the command queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic              press;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  key;
  } event_t;

  function automatic logic [FIFO_AW-1:0] fifo_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/ket_in_if.sv =====
// Request channel of the key event tracker: valid/ready plus one input item.
// Depends on ket_pkg for field widths.
interface ket_in_if;
  logic                          valid;
  logic                          ready;
  logic [ket_pkg::OP_W-1:0]      operation;
  logic [ket_pkg::KEY_W-1:0]     key_code;
  logic [ket_pkg::CODE_W-1:0]    mapped_code;
  logic                          is_press;
  logic [ket_pkg::TIME_W-1:0]    now_usec;

  modport source(output valid, operation, key_code, mapped_code, is_press, now_usec,
                 input ready);
  modport sink(input valid, operation, key_code, mapped_code, is_press, now_usec,
               output ready);
endinterface

// ===== hw/rtl/ket_out_if.sv =====
// Result channel of the key event tracker: valid/ready plus one result item.
// Depends on ket_pkg for field widths.
interface ket_out_if;
  logic                          valid;
  logic                          ready;
  logic                          event_valid;
  logic [ket_pkg::KEY_W-1:0]     event_key;
  logic [ket_pkg::CODE_W-1:0]    event_mapped;
  logic                          event_pressed;
  logic [ket_pkg::TIME_W-1:0]    aligned_ts;
  logic [ket_pkg::TIME_W-1:0]    native_ts;
  logic [ket_pkg::DROP_W-1:0]    drop_count;

  modport source(output valid, event_valid, event_key, event_mapped, event_pressed,
                 aligned_ts, native_ts, drop_count, input ready);
  modport sink(input valid, event_valid, event_key, event_mapped, event_pressed,
               aligned_ts, native_ts, drop_count, output ready);
endinterface

// ===== hw/rtl/ket_front.sv =====
// Front end: accepts requests, filters key events against the held-key table,
// walks the table on focus loss and issues commands. Depends on ket_pkg, ket_in_if.
module ket_front (
  input  logic              clk,
  input  logic              rst_n,
  ket_in_if.sink            in_ch,
  output ket_pkg::push_t    push,
  input  logic              push_ready
);

  localparam int KeyW   = ket_pkg::KEY_W;
  localparam int KeyIdxW = ket_pkg::KEY_IDX_W;
  localparam int CodeW  = ket_pkg::CODE_W;

  typedef enum logic [3:0] {
    F_IDLE     = 4'b0001,
    F_CLASSIFY = 4'b0010,
    F_SCAN     = 4'b0100,
    F_EMIT     = 4'b1000
  } fstate_t;

  fstate_t                     state_r, state_nxt;
  ket_pkg::item_t              item_r;
  logic [ket_pkg::NUM_KEYS-1:0] key_held_r;
  logic [KeyIdxW-1:0]          scan_r, scan_nxt;
  logic [CodeW-1:0]            code_mem [ket_pkg::NUM_KEYS];
  logic [CodeW-1:0]            code_rd_r;

  logic               held_wr;
  logic               held_val;
  logic [KeyIdxW-1:0] held_idx;
  logic               code_we;
  logic               code_re;
  logic [KeyIdxW-1:0] key_idx;
  logic               tracked;
  logic               ignored;
  logic               scan_last;

  assign in_ch.ready = rst_n && (state_r == F_IDLE);

  assign key_idx   = item_r.key[KeyIdxW-1:0];
  assign tracked   = {1'b0, item_r.key} < (KeyW + 1)'(ket_pkg::NUM_KEYS);
  assign ignored   = (item_r.key == ket_pkg::NULL_KEY) || (item_r.key == ket_pkg::IGNORED_KEY);
  assign scan_last = (scan_r == KeyIdxW'(ket_pkg::NUM_KEYS - 1));

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    held_wr   = 1'b0;
    held_val  = 1'b0;
    held_idx  = key_idx;
    code_we   = 1'b0;
    code_re   = 1'b0;
    push      = '0;
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) state_nxt = F_CLASSIFY;
      end
      F_CLASSIFY: begin
        unique case (ket_pkg::op_t'(item_r.op))
          ket_pkg::OP_KEY: begin
            // drop ignored codes, repeated presses and releases of idle keys
            if (ignored || (tracked && (item_r.press == key_held_r[key_idx]))) begin
              state_nxt = F_IDLE;
            end else begin
              push.valid      = 1'b1;
              push.cmd.kind   = ket_pkg::CMD_ENQ;
              push.cmd.key    = item_r.key;
              push.cmd.code   = item_r.code;
              push.cmd.press  = item_r.press;
              push.cmd.stamp  = item_r.stamp;
              if (push_ready) begin
                state_nxt = F_IDLE;
                held_wr   = tracked;
                held_val  = item_r.press;
                code_we   = tracked && item_r.press;
              end
            end
          end
          ket_pkg::OP_FOCUS_LOST: begin
            scan_nxt  = '0;
            state_nxt = F_SCAN;
          end
          ket_pkg::OP_POP: begin
            push.valid    = 1'b1;
            push.cmd.kind = ket_pkg::CMD_POP;
            if (push_ready) state_nxt = F_IDLE;
          end
          ket_pkg::OP_DROP_READ: begin
            push.valid    = 1'b1;
            push.cmd.kind = ket_pkg::CMD_DROP_READ;
            if (push_ready) state_nxt = F_IDLE;
          end
          default: state_nxt = F_IDLE;
        endcase
      end
      F_SCAN: begin
        if (key_held_r[scan_r]) begin
          code_re   = 1'b1;
          state_nxt = F_EMIT;
        end else if (scan_last) begin
          state_nxt = F_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      F_EMIT: begin
        push.valid     = 1'b1;
        push.cmd.kind  = ket_pkg::CMD_ENQ;
        push.cmd.key   = KeyW'(scan_r);
        push.cmd.code  = code_rd_r;
        push.cmd.press = 1'b0;
        push.cmd.stamp = item_r.stamp;
        if (push_ready) begin
          held_wr  = 1'b1;
          held_val = 1'b0;
          held_idx = scan_r;
          if (scan_last) begin
            state_nxt = F_IDLE;
          end else begin
            scan_nxt  = scan_r + 1'b1;
            state_nxt = F_SCAN;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      key_held_r <= '0;
      scan_r     <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      if (held_wr) key_held_r[held_idx] <= held_val;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.op    <= in_ch.operation;
      item_r.key   <= in_ch.key_code;
      item_r.code  <= in_ch.mapped_code;
      item_r.press <= in_ch.is_press;
      item_r.stamp <= in_ch.now_usec;
    end
  end

  // held codes are only read for keys whose held bit is set, so no reset
  always_ff @(posedge clk) begin
    if (code_we) code_mem[key_idx] <= item_r.code;
    if (code_re) code_rd_r <= code_mem[scan_r];
  end

  a_emit_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_EMIT |-> key_held_r[scan_r])
    else $error("release emitted for a key that is not held");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_EMIT && push_ready) |=> !key_held_r[$past(scan_r)])
    else $error("held bit survives its focus-loss release");

endmodule

// ===== hw/rtl/ket_cmd_q.sv =====
// Short command queue between front end and back end.
// Depends on ket_pkg for the command type and depth.
module ket_cmd_q (
  input  logic            clk,
  input  logic            rst_n,
  input  ket_pkg::push_t  push,
  output logic            push_ready,
  output ket_pkg::cmd_t   head,
  output logic            head_valid,
  input  logic            pop
);

  localparam int Aw = ket_pkg::CMDQ_AW;
  localparam int Cw = ket_pkg::CMDQ_CW;

  ket_pkg::cmd_t  entry_r [ket_pkg::CMDQ_DEPTH];
  logic [Aw-1:0]  wr_r, rd_r;
  logic [Cw-1:0]  count_r;
  logic           push_acc;

  assign push_ready = (count_r != Cw'(ket_pkg::CMDQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_r];
  assign push_acc   = push.valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push_acc) wr_r <= (wr_r == Aw'(ket_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)      rd_r <= (rd_r == Aw'(ket_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      case ({push_acc, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) entry_r[wr_r] <= push.cmd;
  end

endmodule

// ===== hw/rtl/ket_back.sv =====
// Back end: event ring FIFO, drop counter, clock offset and result register.
// Depends on ket_pkg and ket_out_if.
module ket_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ket_pkg::OFFSET_W-1:0]      cfg_wdata,
  input  ket_pkg::cmd_t                     head,
  input  logic                              head_valid,
  output logic                              pop,
  ket_out_if.source                         out_ch
);

  localparam int Aw    = ket_pkg::FIFO_AW;
  localparam int TimeW = ket_pkg::TIME_W;
  localparam int DropW = ket_pkg::DROP_W;
  localparam int OffW  = ket_pkg::OFFSET_W;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_READ = 2'b10
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  logic signed [OffW-1:0]  offset_r;
  logic [Aw-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [Aw-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [DropW-1:0]        dropped_r, dropped_nxt;
  ket_pkg::event_t         ev_mem [ket_pkg::FIFO_DEPTH];
  logic [TimeW-1:0]        tm_mem [ket_pkg::FIFO_DEPTH];
  ket_pkg::event_t         ev_rd_r;
  logic [TimeW-1:0]        tm_rd_r;

  logic                    out_valid_r;
  logic                    ev_valid_r;
  ket_pkg::event_t         ev_r;
  logic [TimeW-1:0]        aligned_r, native_r;
  logic [DropW-1:0]        drop_r;

  logic                    out_free;
  logic                    mem_we, mem_re;
  logic                    drop_clr;
  logic                    load;
  logic                    ld_valid;
  ket_pkg::event_t         ld_ev;
  logic [TimeW-1:0]        ld_aligned, ld_native;
  logic signed [TimeW+1:0] sum;
  logic [TimeW-1:0]        aligned;
  logic                    full, empty;

  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = (ket_pkg::fifo_inc(wr_ptr_r) == rd_ptr_r);
  assign empty    = (rd_ptr_r == wr_ptr_r);

  // native plus signed offset, clamped to the 63-bit range
  always_comb begin
    sum = $signed({2'b00, tm_rd_r}) + (TimeW + 2)'(offset_r);
    if (sum[TimeW+1] || (sum == '0)) begin
      aligned = '0;
    end else if (sum[TimeW]) begin
      aligned = '1;
    end else begin
      aligned = sum[TimeW-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    dropped_nxt = dropped_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    drop_clr    = 1'b0;
    load        = 1'b0;
    ld_valid    = 1'b0;
    ld_ev       = '0;
    ld_aligned  = '0;
    ld_native   = '0;
    unique case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          case (head.kind)
            ket_pkg::CMD_ENQ: begin
              pop = 1'b1;
              if (full) begin
                if (dropped_r != '1) dropped_nxt = dropped_r + 1'b1;
              end else begin
                mem_we     = 1'b1;
                wr_ptr_nxt = ket_pkg::fifo_inc(wr_ptr_r);
              end
            end
            ket_pkg::CMD_POP: begin
              if (out_free) begin
                pop = 1'b1;
                if (empty) begin
                  load = 1'b1;
                end else begin
                  mem_re     = 1'b1;
                  rd_ptr_nxt = ket_pkg::fifo_inc(rd_ptr_r);
                  state_nxt  = B_READ;
                end
              end
            end
            ket_pkg::CMD_DROP_READ: begin
              if (out_free) begin
                pop         = 1'b1;
                load        = 1'b1;
                drop_clr    = 1'b1;
                dropped_nxt = '0;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      B_READ: begin
        if (out_free) begin
          load       = 1'b1;
          ld_valid   = 1'b1;
          ld_ev      = ev_rd_r;
          ld_aligned = aligned;
          ld_native  = tm_rd_r;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      offset_r    <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      dropped_r <= dropped_nxt;
      if (cfg_we) offset_r <= cfg_wdata;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; drop count is sampled before any clear
  always_ff @(posedge clk) begin
    if (load) begin
      ev_valid_r <= ld_valid;
      ev_r       <= ld_ev;
      aligned_r  <= ld_aligned;
      native_r   <= ld_native;
      drop_r     <= dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ev_mem[wr_ptr_r] <= '{press: head.press, code: head.code, key: head.key};
      tm_mem[wr_ptr_r] <= head.stamp;
    end
    if (mem_re) begin
      ev_rd_r <= ev_mem[rd_ptr_r];
      tm_rd_r <= tm_mem[rd_ptr_r];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_valid   = ev_valid_r;
  assign out_ch.event_key     = ev_r.key;
  assign out_ch.event_mapped  = ev_r.code;
  assign out_ch.event_pressed = ev_r.press;
  assign out_ch.aligned_ts    = aligned_r;
  assign out_ch.native_ts     = native_r;
  assign out_ch.drop_count    = drop_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ket_pkg::fifo_inc(wr_ptr_r) != rd_ptr_r)
    else $error("event written into a full ring");

  a_drop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (dropped_r < $past(dropped_r)) |-> $past(drop_clr))
    else $error("drop count fell without a drop-count read");

endmodule

// ===== hw/rtl/key_event_tracker_fifo.sv =====
// Key event tracker with a timestamped event ring FIFO.
// Request channel in_ch (valid/ready): operation, key_code, mapped_code, is_press,
// now_usec. Key events and focus loss give no result; pop and drop-count read give
// exactly one result on out_ch (valid/ready), in request order.
// cfg_we/cfg_wdata write the signed clock offset added to timestamps on readout;
// write it only while the block is idle.
// The front end takes a new request only from idle: it registers the request, then
// classifies it against the held-key table and issues its commands into a two-entry
// queue. Focus loss walks the held-key table one key per cycle in F_SCAN; each held
// key also passes through F_EMIT, which issues its release and holds the walk while
// the queue is full. The back end handles a queued event, empty pop or drop-count
// read in B_IDLE; a pop that finds an event also passes through B_READ (registered
// read of the event memory). A request goes through the front-end item register, the
// queue and the result register, and a found event also through the read register.
// Reset (rst_n low, synchronous) clears the held-key bits, pointers, drop count,
// offset and result valid flag; no clearing pass is needed.
// A stalled receiver holds the result; the back end holds a pop or drop-count read
// at the queue head, the queue fills and in_ch.ready stays low until the result drains.
module key_event_tracker_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  ket_in_if.sink                        in_ch,
  ket_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ket_pkg::OFFSET_W-1:0]  cfg_wdata
);

  ket_pkg::push_t push;
  logic           push_ready;
  ket_pkg::cmd_t  head;
  logic           head_valid;
  logic           pop;

  ket_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  ket_cmd_q u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  ket_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
